### rtl/window_alarm_monitor_assert.svh
// Assertion macros for the window alarm monitor. Both forms expect clk_i and
// rst_ni in the scope where they are used.
`ifndef WINDOW_ALARM_MONITOR_ASSERT_SVH
`define WINDOW_ALARM_MONITOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WAM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("window_alarm_monitor: assertion failed");
`define WAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("window_alarm_monitor: assertion failed");
`else
`define WAM_ASSERT(lbl, prop)
`define WAM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/wam_pkg.sv
`default_nettype none

package wam_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned TICK_BITS_DEF   = 16;

  localparam int unsigned OP_W = 2;

  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ENABLE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DISABLE = 2'd2;

  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_START_DELAY  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WARN_MARGIN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_MARGIN = 3'd4;

  // Shared coding for the event kind, the reported band and the latched level.
  typedef enum logic [1:0] {
    LVL_NONE  = 2'd0,
    LVL_WARN  = 2'd1,
    LVL_ALARM = 2'd2
  } level_e;

  typedef struct packed {
    level_e kind;
    logic   has_warning;
    logic   has_alarm;
  } status_t;

endpackage

`default_nettype wire

### rtl/wam_cfg_regs.sv
`default_nettype none

module wam_cfg_regs #(
  parameter int unsigned SAMPLE_BITS = wam_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TICK_BITS   = wam_pkg::TICK_BITS_DEF,
  parameter int unsigned CFG_W       = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output logic                                     ready_o,
  input  wire logic [wam_pkg::CFG_INDEX_W-1:0]     index_i,
  input  wire logic [CFG_W-1:0]                    data_i,
  output logic [TICK_BITS-1:0]                     start_delay_o,
  output logic [TICK_BITS-1:0]                     timeout_o,
  output logic signed [SAMPLE_BITS-1:0]            setpoint_o,
  output logic [SAMPLE_BITS-2:0]                   warn_margin_o,
  output logic [SAMPLE_BITS-2:0]                   alarm_margin_o
);

  logic [TICK_BITS-1:0]          start_delay_q;
  logic [TICK_BITS-1:0]          timeout_q;
  logic signed [SAMPLE_BITS-1:0] setpoint_q;
  logic [SAMPLE_BITS-2:0]        warn_margin_q;
  logic [SAMPLE_BITS-2:0]        alarm_margin_q;

  assign ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q  <= '0;
      timeout_q      <= '0;
      setpoint_q     <= '0;
      warn_margin_q  <= '0;
      alarm_margin_q <= '0;
    end else if (valid_i) begin
      case (index_i)
        wam_pkg::REG_START_DELAY:  start_delay_q  <= data_i[TICK_BITS-1:0];
        wam_pkg::REG_TIMEOUT:      timeout_q      <= data_i[TICK_BITS-1:0];
        wam_pkg::REG_SETPOINT:     setpoint_q     <= data_i[SAMPLE_BITS-1:0];
        wam_pkg::REG_WARN_MARGIN:  warn_margin_q  <= data_i[SAMPLE_BITS-2:0];
        wam_pkg::REG_ALARM_MARGIN: alarm_margin_q <= data_i[SAMPLE_BITS-2:0];
        default: ;
      endcase
    end
  end

  assign start_delay_o  = start_delay_q;
  assign timeout_o      = timeout_q;
  assign setpoint_o     = setpoint_q;
  assign warn_margin_o  = warn_margin_q;
  assign alarm_margin_o = alarm_margin_q;

endmodule

`default_nettype wire

### rtl/wam_judge.sv
`default_nettype none

module wam_judge #(
  parameter int unsigned SAMPLE_BITS = wam_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TICK_BITS   = wam_pkg::TICK_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            fire_i,
  input  wire logic [wam_pkg::OP_W-1:0]        op_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  wire logic [TICK_BITS-1:0]            start_delay_i,
  input  wire logic [TICK_BITS-1:0]            timeout_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   setpoint_i,
  input  wire logic [SAMPLE_BITS-2:0]          warn_margin_i,
  input  wire logic [SAMPLE_BITS-2:0]          alarm_margin_i,
  output wam_pkg::status_t                     status_o,
  output logic signed [SAMPLE_BITS-1:0]        value_o,
  output logic signed [SAMPLE_BITS:0]          band_low_o,
  output logic signed [SAMPLE_BITS:0]          band_high_o
);

  // Tick counters hold delay plus timeout and saturate at minus one.
  localparam int unsigned CW = TICK_BITS + 2;
  localparam int unsigned BW = SAMPLE_BITS + 1;

  logic                 enabled_q, enabled_d;
  logic signed [CW-1:0] start_q, start_d;
  logic signed [CW-1:0] warn_q, warn_d;
  logic signed [CW-1:0] alarm_q, alarm_d;
  wam_pkg::level_e      report_q, report_d;
  wam_pkg::level_e      level_q, level_d;

  logic signed [CW-1:0] start_x, timeout_x, enable_total;
  logic signed [CW-1:0] warn_mid, alarm_mid;
  logic signed [BW-1:0] v_x, sp_x;
  logic signed [BW-1:0] warn_lo, warn_hi, alarm_lo, alarm_hi;
  logic                 in_warn, in_alarm, out_warn, out_alarm, start_done;

  wam_pkg::level_e      kind;
  logic signed [SAMPLE_BITS-1:0] value;
  logic signed [BW-1:0] band_lo, band_hi;

  function automatic logic signed [CW-1:0] tick_down(input logic signed [CW-1:0] c);
    return c[CW-1] ? c : c - CW'(1);
  endfunction

  assign start_x      = $signed({2'b00, start_delay_i});
  assign timeout_x    = $signed({2'b00, timeout_i});
  assign enable_total = start_x + timeout_x;

  assign v_x      = BW'(sample_i);
  assign sp_x     = BW'(setpoint_i);
  assign warn_lo  = sp_x - $signed({2'b00, warn_margin_i});
  assign warn_hi  = sp_x + $signed({2'b00, warn_margin_i});
  assign alarm_lo = sp_x - $signed({2'b00, alarm_margin_i});
  assign alarm_hi = sp_x + $signed({2'b00, alarm_margin_i});

  // Strict limits: a value equal to a limit is neither inside nor outside.
  assign in_warn   = (v_x < warn_hi) && (v_x > warn_lo);
  assign in_alarm  = (v_x < alarm_hi) && (v_x > alarm_lo);
  assign out_warn  = (v_x > warn_hi) || (v_x < warn_lo);
  assign out_alarm = (v_x > alarm_hi) || (v_x < alarm_lo);

  assign start_done = start_q[CW-1] || (start_q == '0);

  always_comb begin
    enabled_d = enabled_q;
    start_d   = start_q;
    warn_d    = warn_q;
    alarm_d   = alarm_q;
    report_d  = report_q;
    level_d   = level_q;
    warn_mid  = warn_q;
    alarm_mid = alarm_q;
    kind      = wam_pkg::LVL_NONE;
    value     = '0;
    band_lo   = '0;
    band_hi   = '0;
    case (op_i)
      wam_pkg::OP_ENABLE: begin
        start_d   = start_x;
        warn_d    = enable_total;
        alarm_d   = enable_total;
        enabled_d = 1'b1;
        report_d  = wam_pkg::LVL_NONE;
        level_d   = wam_pkg::LVL_NONE;
      end
      wam_pkg::OP_DISABLE: begin
        enabled_d = 1'b0;
        report_d  = wam_pkg::LVL_NONE;
        level_d   = wam_pkg::LVL_NONE;
      end
      wam_pkg::OP_SAMPLE: begin
        if (enabled_q && start_done) begin
          if (in_warn) warn_mid = timeout_x;
          if (in_alarm) alarm_mid = timeout_x;
          // The alarm band wins; a band already reported stays quiet.
          if (out_alarm && alarm_mid[CW-1]) begin
            if (report_q != wam_pkg::LVL_ALARM) begin
              kind    = wam_pkg::LVL_ALARM;
              value   = sample_i;
              band_lo = alarm_lo;
              band_hi = alarm_hi;
              level_d = wam_pkg::LVL_ALARM;
            end
            report_d = wam_pkg::LVL_ALARM;
          end else if (out_warn && warn_mid[CW-1]) begin
            if (report_q == wam_pkg::LVL_NONE) begin
              kind    = wam_pkg::LVL_WARN;
              value   = sample_i;
              band_lo = warn_lo;
              band_hi = warn_hi;
              if (level_q == wam_pkg::LVL_NONE) level_d = wam_pkg::LVL_WARN;
            end
            report_d = wam_pkg::LVL_WARN;
          end else begin
            report_d = wam_pkg::LVL_NONE;
          end
        end
        start_d = tick_down(start_q);
        warn_d  = tick_down(warn_mid);
        alarm_d = tick_down(alarm_mid);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      start_q   <= '0;
      warn_q    <= '0;
      alarm_q   <= '0;
      report_q  <= wam_pkg::LVL_NONE;
      level_q   <= wam_pkg::LVL_NONE;
    end else if (fire_i) begin
      enabled_q <= enabled_d;
      start_q   <= start_d;
      warn_q    <= warn_d;
      alarm_q   <= alarm_d;
      report_q  <= report_d;
      level_q   <= level_d;
    end
  end

  assign status_o.kind        = kind;
  assign status_o.has_warning = (level_d != wam_pkg::LVL_NONE);
  assign status_o.has_alarm   = (level_d == wam_pkg::LVL_ALARM);
  assign value_o              = value;
  assign band_low_o           = band_lo;
  assign band_high_o          = band_hi;

endmodule

`default_nettype wire

### rtl/window_alarm_monitor.sv
// Channel   Dir  Beat contents
// s_axis    in   tuser: operation; tdata: sample_value
// m_axis    out  tuser: event_kind; tdata: reported_value, band_low, band_high,
//                has_warning, has_alarm
// cfg       in   cfg_index_i selects the register, cfg_data_i carries the value
//
// One beat is accepted per cycle unless s_axis_tready is low. A beat taken is held in the input
// register, judged from it when it moves on, and its result is captured in the output register
// that drives m_axis.
// While a result waits, the input register still takes one more beat; s_axis_tready
// is low only when both stages hold a beat and m_axis_tready is low. Reset clears
// the monitor state, both valid flags and all configuration registers to zero.
`default_nettype none
`include "window_alarm_monitor_assert.svh"

module window_alarm_monitor #(
  parameter int unsigned SAMPLE_BITS = wam_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TICK_BITS   = wam_pkg::TICK_BITS_DEF,
  localparam int unsigned CfgW     = (SAMPLE_BITS > TICK_BITS) ? SAMPLE_BITS : TICK_BITS,
  localparam int unsigned InDataW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OutBits  = 3 * SAMPLE_BITS + 4,
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [InDataW-1:0]              s_axis_tdata,  // sample_value
  input  wire logic [wam_pkg::OP_W-1:0]        s_axis_tuser,  // operation
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // reported_value, band_low, band_high, has_warning, has_alarm, zero fill
  output logic [OutDataW-1:0]                  m_axis_tdata,
  output logic [1:0]                           m_axis_tuser,  // event_kind
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [wam_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]                 cfg_data_i
);

  logic [TICK_BITS-1:0]          start_delay;
  logic [TICK_BITS-1:0]          timeout;
  logic signed [SAMPLE_BITS-1:0] setpoint;
  logic [SAMPLE_BITS-2:0]        warn_margin;
  logic [SAMPLE_BITS-2:0]        alarm_margin;

  logic                          in_valid_q;
  logic [wam_pkg::OP_W-1:0]      in_op_q;
  logic signed [SAMPLE_BITS-1:0] in_sample_q;

  logic                          out_valid_q;
  wam_pkg::status_t              out_status_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic signed [SAMPLE_BITS:0]   out_lo_q, out_hi_q;

  wam_pkg::status_t              status_d;
  logic signed [SAMPLE_BITS-1:0] value_d;
  logic signed [SAMPLE_BITS:0]   lo_d, hi_d;

  logic in_accept, advance;
  logic out_is_alarm, out_is_quiet, out_fields_zero, out_flags_clear, disable_fire;

  wam_cfg_regs #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TICK_BITS  (TICK_BITS),
    .CFG_W      (CfgW)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (cfg_valid_i),
    .ready_o       (cfg_ready_o),
    .index_i       (cfg_index_i),
    .data_i        (cfg_data_i),
    .start_delay_o (start_delay),
    .timeout_o     (timeout),
    .setpoint_o    (setpoint),
    .warn_margin_o (warn_margin),
    .alarm_margin_o(alarm_margin)
  );

  // The held beat moves on when the result register is empty or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q     <= s_axis_tuser;
      in_sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  wam_judge #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TICK_BITS  (TICK_BITS)
  ) u_judge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (advance),
    .op_i          (in_op_q),
    .sample_i      (in_sample_q),
    .start_delay_i (start_delay),
    .timeout_i     (timeout),
    .setpoint_i    (setpoint),
    .warn_margin_i (warn_margin),
    .alarm_margin_i(alarm_margin),
    .status_o      (status_d),
    .value_o       (value_d),
    .band_low_o    (lo_d),
    .band_high_o   (hi_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= status_d;
      out_value_q  <= value_d;
      out_lo_q     <= lo_d;
      out_hi_q     <= hi_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q.kind;
  assign m_axis_tdata  = OutDataW'({out_status_q.has_alarm, out_status_q.has_warning,
                                    out_hi_q, out_lo_q, out_value_q});

  assign out_is_alarm    = out_valid_q && (out_status_q.kind == wam_pkg::LVL_ALARM);
  assign out_is_quiet    = out_valid_q && (out_status_q.kind == wam_pkg::LVL_NONE);
  assign out_fields_zero = (out_lo_q == '0) && (out_hi_q == '0) && (out_value_q == '0);
  assign out_flags_clear = out_valid_q && !out_status_q.has_warning
                           && !out_status_q.has_alarm;
  assign disable_fire    = advance && (in_op_q == wam_pkg::OP_DISABLE);

  `WAM_ASSERT(a_alarm_sets_flag, out_is_alarm |-> out_status_q.has_alarm)
  `WAM_ASSERT(a_alarm_has_warning, out_valid_q && out_status_q.has_alarm |-> out_status_q.has_warning)
  `WAM_ASSERT(a_quiet_zero_band, out_is_quiet |-> out_fields_zero)
  `WAM_ASSERT_NEXT(a_disable_clears, disable_fire, out_flags_clear)

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [wam_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
  localparam logic [wam_pkg::CFG_INDEX_W-1:0] REG_NONE = 3'd7;
  localparam int unsigned DIRECTED_REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [16:0] band_lo;
    logic [16:0] band_hi;
    logic        has_warning;
    logic        has_alarm;
  } band_report_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [15:0]                     s_axis_tdata;   // sample_value
  logic [wam_pkg::OP_W-1:0]        s_axis_tuser;   // operation
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // reported_value, band_low, band_high, has_warning, has_alarm, zero fill
  logic [55:0]                     m_axis_tdata;
  logic [1:0]                      m_axis_tuser;   // event_kind
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [wam_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [15:0]                     cfg_data_i;

  window_alarm_monitor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the monitor's registers and state.
  int              delay_q, timeout_q, setpoint_q, warn_off_q, alarm_off_q;
  bit              mon_enabled;
  int              start_left, warn_left, alarm_left;
  wam_pkg::level_e report_state, latched_level;

  band_report_t expected_reports[$];
  int           mismatch_count;
  int unsigned  src_idle_pct, sink_stall_pct;
  logic [15:0]  last_sample;

  always #5 clk_i = ~clk_i;

  function automatic int count_down(int c);
    return (c > -1) ? c - 1 : -1;
  endfunction

  function automatic band_report_t predict_monitor_step(logic [1:0] op, logic [15:0] raw);
    band_report_t r;
    int  v, wl, wh, al, ah;
    bit  done;
    r  = '0;
    v  = int'($signed(raw));
    wl = setpoint_q - warn_off_q;
    wh = setpoint_q + warn_off_q;
    al = setpoint_q - alarm_off_q;
    ah = setpoint_q + alarm_off_q;
    case (op)
      wam_pkg::OP_ENABLE: begin
        start_left    = delay_q;
        warn_left     = delay_q + timeout_q;
        alarm_left    = warn_left;
        mon_enabled   = 1'b1;
        report_state  = wam_pkg::LVL_NONE;
        latched_level = wam_pkg::LVL_NONE;
      end
      wam_pkg::OP_DISABLE: begin
        mon_enabled   = 1'b0;
        report_state  = wam_pkg::LVL_NONE;
        latched_level = wam_pkg::LVL_NONE;
      end
      wam_pkg::OP_SAMPLE: begin
        if (mon_enabled && start_left <= 0) begin
          done = 1'b0;
          // A value on a limit is neither inside nor outside that band.
          if (v < wh && v > wl) warn_left = timeout_q;
          if (v < ah && v > al) alarm_left = timeout_q;
          if ((v > ah || v < al) && alarm_left < 0) begin
            if (report_state != wam_pkg::LVL_ALARM) begin
              r.kind        = wam_pkg::LVL_ALARM;
              r.value       = raw;
              r.band_lo     = al[16:0];
              r.band_hi     = ah[16:0];
              latched_level = wam_pkg::LVL_ALARM;
            end
            report_state = wam_pkg::LVL_ALARM;
            done         = 1'b1;
          end
          if (!done && (v > wh || v < wl) && warn_left < 0) begin
            if (report_state == wam_pkg::LVL_NONE) begin
              r.kind    = wam_pkg::LVL_WARN;
              r.value   = raw;
              r.band_lo = wl[16:0];
              r.band_hi = wh[16:0];
              if (latched_level == wam_pkg::LVL_NONE) latched_level = wam_pkg::LVL_WARN;
            end
            report_state = wam_pkg::LVL_WARN;
            done         = 1'b1;
          end
          if (!done) report_state = wam_pkg::LVL_NONE;
        end
        start_left = count_down(start_left);
        warn_left  = count_down(warn_left);
        alarm_left = count_down(alarm_left);
      end
      default: begin
      end
    endcase
    r.has_warning = (latched_level != wam_pkg::LVL_NONE);
    r.has_alarm   = (latched_level == wam_pkg::LVL_ALARM);
    return r;
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    band_report_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind        = m_axis_tuser;
        got.value       = m_axis_tdata[15:0];
        got.band_lo     = m_axis_tdata[32:16];
        got.band_hi     = m_axis_tdata[49:33];
        got.has_warning = m_axis_tdata[50];
        got.has_alarm   = m_axis_tdata[51];
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= DIRECTED_REPORT_LIMIT)
            $display("%0t: result beat with nothing expected, kind=%0d value=%0d",
                     $realtime, got.kind, $signed(got.value));
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= DIRECTED_REPORT_LIMIT) begin
              $display("%0t: expected kind=%0d value=%0d lo=%0d hi=%0d warn=%b alarm=%b",
                       $realtime, want.kind, $signed(want.value), $signed(want.band_lo),
                       $signed(want.band_hi), want.has_warning, want.has_alarm);
              $display("%0t:   actual kind=%0d value=%0d lo=%0d hi=%0d warn=%b alarm=%b",
                       $realtime, got.kind, $signed(got.value), $signed(got.band_lo),
                       $signed(got.band_hi), got.has_warning, got.has_alarm);
            end
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_item(logic [1:0] op, logic [15:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_reports.push_back(predict_monitor_step(op, value));
  endtask

  // Stops sending and lets every outstanding result drain before a register write.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [wam_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      wam_pkg::REG_START_DELAY:  delay_q     = int'(data);
      wam_pkg::REG_TIMEOUT:      timeout_q   = int'(data);
      wam_pkg::REG_SETPOINT:     setpoint_q  = int'($signed(data));
      wam_pkg::REG_WARN_MARGIN:  warn_off_q  = int'(data[14:0]);
      wam_pkg::REG_ALARM_MARGIN: alarm_off_q = int'(data[14:0]);
      default: begin
      end
    endcase
  endtask

  task automatic program_registers(logic [15:0] delay, logic [15:0] timeout,
                                   logic [15:0] setpoint, logic [15:0] warn_off,
                                   logic [15:0] alarm_off);
    write_reg(wam_pkg::REG_START_DELAY, delay);
    write_reg(wam_pkg::REG_TIMEOUT, timeout);
    write_reg(wam_pkg::REG_SETPOINT, setpoint);
    write_reg(wam_pkg::REG_WARN_MARGIN, warn_off);
    write_reg(wam_pkg::REG_ALARM_MARGIN, alarm_off);
    cfg_valid_i <= 1'b0;
  endtask

  // Picks a value around the setpoint so that band limits are hit exactly and often.
  function automatic logic [15:0] pick_sample();
    int span, v;
    span = ((alarm_off_q > warn_off_q) ? alarm_off_q : warn_off_q) + 3;
    v    = setpoint_q + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic test_reset_values();
    // Registers still hold their reset value of zero here.
    send_item(wam_pkg::OP_SAMPLE, 16'sd5);
    send_item(wam_pkg::OP_ENABLE, 16'hFFFF);
    send_item(wam_pkg::OP_SAMPLE, 16'sd5);
    send_item(wam_pkg::OP_SAMPLE, 16'sd5);
    send_item(wam_pkg::OP_SAMPLE, 16'sd0);
    send_item(wam_pkg::OP_SAMPLE, -16'sd3);
  endtask

  task automatic test_directed_bands();
    wait_idle();
    program_registers(16'd2, 16'd1, 16'sd100, 16'd10, 16'd20);
    send_item(wam_pkg::OP_SAMPLE, 16'sd105);
    send_item(OP_RESERVED, 16'hFFFF);
    send_item(wam_pkg::OP_DISABLE, 16'h0000);
    send_item(wam_pkg::OP_ENABLE, 16'h0000);
    send_item(wam_pkg::OP_SAMPLE, 16'sd200);
    send_item(wam_pkg::OP_SAMPLE, 16'sd200);
    send_item(wam_pkg::OP_SAMPLE, 16'sd110);
    send_item(wam_pkg::OP_SAMPLE, 16'sd111);
    send_item(wam_pkg::OP_SAMPLE, 16'sd111);
    send_item(wam_pkg::OP_SAMPLE, 16'sd111);
    send_item(wam_pkg::OP_SAMPLE, 16'sd120);
    send_item(wam_pkg::OP_SAMPLE, 16'sd121);
    send_item(wam_pkg::OP_SAMPLE, 16'sd121);
    send_item(wam_pkg::OP_SAMPLE, 16'sd115);
    send_item(wam_pkg::OP_SAMPLE, 16'sd100);
    send_item(wam_pkg::OP_SAMPLE, 16'h7FFF);
    send_item(wam_pkg::OP_SAMPLE, 16'h8000);
    send_item(wam_pkg::OP_SAMPLE, 16'h8000);
    send_item(wam_pkg::OP_SAMPLE, 16'h8000);
    send_item(wam_pkg::OP_DISABLE, 16'hFFFF);
    send_item(wam_pkg::OP_SAMPLE, 16'h7FFF);
    send_item(wam_pkg::OP_ENABLE, 16'h5A5A);
    send_item(wam_pkg::OP_SAMPLE, 16'sd79);
    send_item(OP_RESERVED, 16'h0000);
    send_item(wam_pkg::OP_SAMPLE, 16'sd80);
  endtask

  task automatic test_register_extremes();
    // Widest bands at both ends of the setpoint range, then the longest start delay and timeout.
    wait_idle();
    write_reg(REG_NONE, 16'hFFFF);
    program_registers(16'd0, 16'd0, 16'h8000, 16'hFFFF, 16'h0000);
    send_item(wam_pkg::OP_ENABLE, 16'h0000);
    for (int i = 0; i < 4; i++) send_item(wam_pkg::OP_SAMPLE, i[0] ? 16'h7FFF : 16'h8000);
    send_item(wam_pkg::OP_SAMPLE, 16'h0000);
    wait_idle();
    program_registers(16'd0, 16'd0, 16'h7FFF, 16'h0000, 16'h7FFF);
    send_item(wam_pkg::OP_ENABLE, 16'h0000);
    for (int i = 0; i < 4; i++) send_item(wam_pkg::OP_SAMPLE, i[0] ? 16'h8000 : 16'h7FFF);
    send_item(wam_pkg::OP_SAMPLE, 16'h7FFE);
    wait_idle();
    program_registers(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002);
    send_item(wam_pkg::OP_ENABLE, 16'h0000);
    for (int i = 0; i < 6; i++) send_item(wam_pkg::OP_SAMPLE, 16'h7FFF);
    send_item(wam_pkg::OP_ENABLE, 16'h0000);
    send_item(wam_pkg::OP_SAMPLE, 16'h8000);
  endtask

  task automatic program_random_setting();
    logic [15:0] sp;
    if ($urandom_range(7) == 0) sp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    else sp = 16'($urandom);
    program_registers(16'($urandom_range(0, 8)), 16'($urandom_range(0, 6)), sp,
                      16'($urandom_range(0, 30)) | (16'($urandom_range(1)) << 15),
                      16'($urandom_range(0, 60)) | (16'($urandom_range(1)) << 15));
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     int items);
    int unsigned pick;
    int          counted;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    for (int s = 0; s < 2; s++) begin
      wait_idle();
      program_random_setting();
      send_item(wam_pkg::OP_ENABLE, 16'($urandom));
      last_sample = pick_sample();
      counted = 0;
      while (counted < items / 2) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          send_item(wam_pkg::OP_ENABLE, 16'($urandom));
        end else if (pick < 5) begin
          send_item(wam_pkg::OP_DISABLE, 16'($urandom));
        end else if (pick < 6) begin
          send_item(OP_RESERVED, 16'($urandom));
          continue;
        end else begin
          // Values tend to persist so that a band is left for longer than the timeout.
          if (pick < 11) last_sample = 16'($urandom);
          else if ($urandom_range(1) == 0) last_sample = pick_sample();
          send_item(wam_pkg::OP_SAMPLE, last_sample);
        end
        counted++;
      end
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = wam_pkg::OP_SAMPLE;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = wam_pkg::REG_START_DELAY;
    cfg_data_i     = '0;
    mismatch_count = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    delay_q        = 0;
    timeout_q      = 0;
    setpoint_q     = 0;
    warn_off_q     = 0;
    alarm_off_q    = 0;
    mon_enabled    = 1'b0;
    start_left     = 0;
    warn_left      = 0;
    alarm_left     = 0;
    report_state   = wam_pkg::LVL_NONE;
    latched_level  = wam_pkg::LVL_NONE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_bands();
    test_register_extremes();
    test_random_traffic(0, 0, 470);
    test_random_traffic(75, 0, 470);
    test_random_traffic(0, 75, 470);
    test_random_traffic(21, 21, 470);

    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
